// ----- sv/smx_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package smx_pkg;

   // Quadratic correction polynomial magnitudes, Q0.24
   localparam logic [22:0] POLY_A0 = 23'd5150066;
   localparam logic [20:0] POLY_A1 = 21'd1100386;
   localparam logic [17:0] POLY_A2 = 18'd227428;
   // Clamp of the negative difference: 127.0 in Q8.16
   localparam logic [22:0] CLAMP_MAG = 23'(127 * 65536);
   // Quotient bits of the reciprocal 2^40 / sum
   localparam int RECIP_W = 41;
   localparam logic [5:0] DIV_TOP = 6'(RECIP_W - 1);

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;
      logic run_init;
      logic inc_idx;
      logic acc;
      logic div_init;
      logic div_step;
      logic emit;
      logic end_run;
   } cmd_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic full;
      logic idx_last;
      logic div_last;
   } sts_type;

endpackage
`default_nettype wire

// ----- sv/smx_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
module smx_ctrl
   import smx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   input  wire logic    req_last,
   input  wire sts_type sts,
   output cmd_type      cmd,
   output logic         busy
);

   typedef enum logic [9:0] {
      ST_IDLE = 10'b0000000001,
      ST_RD   = 10'b0000000010,
      ST_W1   = 10'b0000000100,
      ST_W2   = 10'b0000001000,
      ST_W3   = 10'b0000010000,
      ST_W4   = 10'b0000100000,
      ST_ACC  = 10'b0001000000,
      ST_DIV  = 10'b0010000000,
      ST_PM   = 10'b0100000000,
      ST_EMIT = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      pass_ff, pass_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      pass_in  = pass_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (sts.full) begin
                  cmd.run_init = 1'b1;
                  pass_in      = 1'b0;
                  state_in     = ST_RD;
               end else begin
                  cmd.load = 1'b1;
                  if (req_last) begin
                     cmd.run_init = 1'b1;
                     pass_in      = 1'b0;
                     state_in     = ST_RD;
                  end
               end
            end
         end
         ST_RD: state_in = ST_W1;
         ST_W1: state_in = ST_W2;
         ST_W2: state_in = ST_W3;
         ST_W3: state_in = ST_W4;
         ST_W4: state_in = pass_ff ? ST_PM : ST_ACC;
         ST_ACC: begin
            cmd.acc = 1'b1;
            if (sts.idx_last) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIV;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_RD;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               cmd.run_init = 1'b1;
               pass_in      = 1'b1;
               state_in     = ST_RD;
            end
         end
         ST_PM: state_in = ST_EMIT;
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.idx_last) begin
               cmd.end_run = 1'b1;
               state_in    = ST_IDLE;
            end else begin
               cmd.inc_idx = 1'b1;
               state_in    = ST_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pass_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pass_ff  <= pass_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

`ifndef SYNTHESIS
   a_acc_pass0: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> !pass_ff)
      else $error("sum step outside first pass");
   a_pm_pass1: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_PM |-> pass_ff)
      else $error("product step outside second pass");
   a_full_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && start && sts.full) |=> state_ff == ST_RD)
      else $error("full store did not start a run");
`endif

endmodule
`default_nettype wire

// ----- sv/smx_dpath.sv -----
`timescale 1ns / 1ps
`default_nettype none
module smx_dpath
   import smx_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   input  wire logic signed [23:0] req_logit,
   output sts_type                 sts,
   output logic                    rsp_strobe,
   output logic [15:0]             rsp_probability,
   output logic [5:0]              rsp_position,
   output logic                    rsp_final_res
);

   localparam int IDX_W = $clog2(MAX_ITEMS);
   localparam int CNT_W = $clog2(MAX_ITEMS + 1);

   // Logit store
   logic [23:0] mem [MAX_ITEMS];
   logic [23:0] rdata_ff;

   logic [CNT_W-1:0]  count_ff;
   logic [IDX_W-1:0]  idx_ff;
   logic signed [23:0] max_ff;
   logic [23:0]       sum_ff;

   // Weight chain registers
   logic [6:0]  k_ff;
   logic [15:0] f_ff;
   logic [17:0] t1_ff;
   logic [14:0] g_ff;
   logic [20:0] t2_ff;
   logic [16:0] w_ff;

   // Reciprocal divider
   logic [RECIP_W-1:0] q_ff;
   logic [23:0]        rem_ff;
   logic [5:0]         dcnt_ff;

   // Output products
   logic [37:0] ph_ff;
   logic [36:0] pl_ff;

   logic               rsp_strobe_ff;
   logic [15:0]        prob_ff;
   logic [5:0]         pos_ff;
   logic               fin_ff;

   // Difference to maximum, clamp, split
   logic signed [24:0] diff;
   logic [24:0]        nraw;
   logic [22:0]        n;
   logic [23:0]        nround;
   always_comb begin
      diff = {rdata_ff[23], rdata_ff} - {max_ff[23], max_ff};
      nraw = diff[24] ? 25'(-diff) : '0;
      n    = (nraw > 25'(CLAMP_MAG)) ? CLAMP_MAG : nraw[22:0];
      nround = {1'b0, n} + 24'd65535;
   end

   // Polynomial products
   logic [33:0] a2f;
   logic [32:0] ff1;
   logic [36:0] a1f;
   logic [22:0] m;
   logic [37:0] mg;
   logic [16:0] p;
   always_comb begin
      a2f = 34'(POLY_A2) * 34'(f_ff);
      ff1 = 33'(f_ff) * (33'd65536 - 33'(f_ff));
      a1f = 37'(POLY_A1 + 21'(t1_ff)) * 37'(f_ff);
      m   = POLY_A0 + 23'(t2_ff);
      mg  = 38'(m) * 38'(g_ff);
      p   = 17'd65536 + 17'(f_ff) - 17'(mg[37:24]);
   end

   // Divider step
   logic [24:0] dshift;
   logic        dge;
   always_comb begin
      dshift = {rem_ff, (dcnt_ff == DIV_TOP)};
      dge    = dshift >= {1'b0, sum_ff};
   end

   // Scaled probability
   logic [57:0] prod;
   logic [33:0] pscaled;
   always_comb begin
      prod    = {ph_ff, 20'd0} + 58'(pl_ff);
      pscaled = prod[57:24];
   end

   // Store write, registered read, weight chain
   always_ff @(posedge clock) begin
      if (cmd.load) mem[count_ff[IDX_W-1:0]] <= req_logit;
      rdata_ff <= mem[idx_ff];
      k_ff  <= nround[22:16];
      f_ff  <= 16'd0 - n[15:0];
      t1_ff <= a2f[33:16];
      g_ff  <= ff1[30:16];
      t2_ff <= a1f[36:16];
      w_ff  <= p >> k_ff;
      ph_ff <= 38'(w_ff) * 38'(q_ff[40:20]);
      pl_ff <= 37'(w_ff) * 37'(q_ff[19:0]);
      prob_ff <= (pscaled > 34'd65535) ? 16'hFFFF : pscaled[15:0];
      pos_ff  <= 6'(idx_ff);
      fin_ff  <= sts.idx_last;
   end

   // Run control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         max_ff        <= '0;
         sum_ff        <= '0;
         idx_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.emit;
         if (cmd.load) begin
            count_ff <= count_ff + 1'b1;
            if (req_logit > max_ff) max_ff <= req_logit;
         end
         if (cmd.end_run) begin
            count_ff <= '0;
            max_ff   <= '0;
         end
         if (cmd.run_init) idx_ff <= '0;
         else if (cmd.inc_idx) idx_ff <= idx_ff + 1'b1;
         if (cmd.run_init && !cmd.div_step) sum_ff <= '0;
         else if (cmd.acc) sum_ff <= sum_ff + 24'(w_ff);
      end
   end

   // Restoring division of 2^40 by the weight sum
   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         q_ff    <= '0;
         rem_ff  <= '0;
         dcnt_ff <= DIV_TOP;
      end else if (cmd.div_step) begin
         q_ff    <= {q_ff[RECIP_W-2:0], dge};
         rem_ff  <= dge ? 24'(dshift - {1'b0, sum_ff}) : dshift[23:0];
         dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   assign sts.full     = (count_ff == CNT_W'(MAX_ITEMS));
   assign sts.idx_last = ((CNT_W'(idx_ff) + 1'b1) == count_ff);
   assign sts.div_last = (dcnt_ff == 6'd0);

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_probability = prob_ff;
   assign rsp_position    = pos_ff;
   assign rsp_final_res   = fin_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ITEMS))
      else $error("item count above store depth");
   a_no_load_full: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !sts.full)
      else $error("write into a full store");
   a_max_floor: assert property (@(posedge clock) disable iff (reset)
      !max_ff[23])
      else $error("running maximum below zero");
`endif

endmodule
`default_nettype wire

// ----- sv/softmax_exp2_polynomial.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Base-2 softmax over runs of up to MAX_ITEMS signed Q8.16 logits. Each
// item is taken while busy is low; an item with req_last set,
// or any item that arrives while the store is full (that item is dropped),
// starts the run computation and busy stays high until the last result.
// The run first forms the weight sum over the stored logits, then the
// bit-serial reciprocal, then one output per logit, all paced by the
// multi-step weight chain and the divider. Results come out in load order,
// one per rsp_strobe pulse, and the receiver cannot stall them, so it must
// take each strobe as it comes.
module softmax_exp2_polynomial
   import smx_pkg::*;
#(
   parameter int MAX_ITEMS = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic signed [23:0] req_logit,
   input  wire logic               req_last,
   output logic                    rsp_strobe,
   output logic [15:0]             rsp_probability,
   output logic [5:0]              rsp_position,
   output logic                    rsp_final_res
);

   cmd_type cmd;
   sts_type sts;

   smx_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_last (req_last),
      .sts      (sts),
      .cmd      (cmd),
      .busy     (busy)
   );

   smx_dpath #(.MAX_ITEMS(MAX_ITEMS)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .req_logit       (req_logit),
      .sts             (sts),
      .rsp_strobe      (rsp_strobe),
      .rsp_probability (rsp_probability),
      .rsp_position    (rsp_position),
      .rsp_final_res   (rsp_final_res)
   );

endmodule
`default_nettype wire

// ----- bench/tb_softmax_exp2_polynomial.sv -----
`timescale 1ns / 1ps
// Softmax scoreboard: models the logit store and running maximum, and queues
// the expected probabilities of each run when it closes.
class softmax_board;
   typedef struct {
      logic [15:0] prob;
      logic [5:0]  pos;
      logic        fin;
   } prob_rec;

   logic signed [23:0] logits[64];
   int unsigned        count;
   logic signed [23:0] peak;
   prob_rec            pending[$];
   int                 errors;

   function new();
      count = 0;
      peak = 0;
      errors = 0;
   endfunction

   // base-2 weight of one stored logit against the run maximum
   function automatic logic [16:0] weight(logic signed [23:0] v);
      longint d;
      longint unsigned n, k, f, t, m, g, p;
      d = longint'(v) - longint'(peak);
      if (d > 0) d = 0;
      n = -d;
      if (n > 127 * 65536) n = 127 * 65536;
      k = (n + 65535) >> 16;
      f = (65536 - (n & 16'hFFFF)) & 16'hFFFF;
      t = (64'd227428 * f) >> 16;
      t = ((64'd1100386 + t) * f) >> 16;
      m = 64'd5150066 + t;
      g = (f * (65536 - f)) >> 16;
      p = 65536 + f - ((m * g) >> 24);
      if (k >= 32) return '0;
      return 17'(p >> k);
   endfunction

   function void close_run();
      longint unsigned total, recip, w, pr;
      prob_rec r;
      total = 0;
      recip = 0;
      for (int i = 0; i < count; i++) total += weight(logits[i]);
      total &= 24'hFFFFFF;
      if (total != 0) recip = (64'd1 << 40) / total;
      for (int i = 0; i < count; i++) begin
         w = weight(logits[i]);
         pr = (w * recip) >> 24;
         if (pr > 65535) pr = 65535;
         r.prob = 16'(pr);
         r.pos = 6'(i);
         r.fin = (i + 1 == count);
         pending = {pending, r};
      end
      count = 0;
      peak = 0;
   endfunction

   function void note_item(logic signed [23:0] v, logic lst);
      if (count >= 64) begin
         close_run();
         return;
      end
      logits[count] = v;
      count++;
      if (v > peak) peak = v;
      if (lst) close_run();
   endfunction

   function void check_result(logic [15:0] prob, logic [5:0] pos, logic fin);
      prob_rec r;
      if (pending.size() == 0) begin
         errors++;
         if (errors <= 10) $display("unexpected result pos %0d prob %0d", pos, prob);
         return;
      end
      r = pending.pop_front();
      if (r.prob !== prob || r.pos !== pos || r.fin !== fin) begin
         errors++;
         if (errors <= 10)
            $display("mismatch: exp prob %0d pos %0d fin %0b, got prob %0d pos %0d fin %0b",
                     r.prob, r.pos, r.fin, prob, pos, fin);
      end
   endfunction
endclass

module tb_softmax_exp2_polynomial;
   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic signed [23:0] req_logit = 0;
   logic               req_last = 0;
   logic               rsp_strobe;
   logic [15:0]        rsp_probability;
   logic [5:0]         rsp_position;
   logic               rsp_final_res;

   softmax_board board = new();
   int               idle_pct = 37;
   longint           cycles = 0;
   localparam longint CYCLE_LIMIT = 400000;

   softmax_exp2_polynomial u_top (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   // result checker and watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_strobe)
         board.check_result(rsp_probability, rsp_position, rsp_final_res);
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // present one item, hold it until accepted, with random idle before it
   task automatic send_item(logic signed [23:0] v, logic lst);
      while ($urandom_range(99) < idle_pct) begin
         start <= 0;
         @(posedge clock);
      end
      start <= 1;
      req_logit <= v;
      req_last <= lst;
      @(posedge clock);
      while (busy) @(posedge clock);
      board.note_item(v, lst);
   endtask

   function automatic logic signed [23:0] rand_logit();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return signed'(24'($urandom_range(8 * 65536))) - 24'sd262144;
         2: return -24'sd1 * 24'($urandom_range(200 * 65536));
         default: return 24'($urandom_range(65536 * 3));
      endcase
   endfunction

   // a run of n items, last flagged unless the run is left to overflow
   task automatic send_run(int n, bit flag_last);
      for (int i = 0; i < n; i++)
         send_item(rand_logit(), flag_last && (i == n - 1));
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, single item, all negative, clamp, zero sum
      send_item(24'sh7FFFFF, 0);
      send_item(-24'sh800000, 0);
      send_item(24'sh000000, 1);
      send_item(24'sh010000, 1);
      send_item(-24'sh000001, 0);
      send_item(-24'sh010000, 0);
      send_item(-24'sh018000, 1);
      send_item(-24'sh7F0000, 0);
      send_item(-24'sh7F0001, 1);
      send_item(-24'sh200000, 0);
      send_item(-24'sh300000, 1);
      send_item(24'sh00FFFF, 0);
      send_item(24'sh555555, 0);
      send_item(-24'sh2AAAAB, 1);
      // store full: 64 loaded, next item dropped and closes the run
      for (int i = 0; i < 64; i++) send_item(rand_logit(), 0);
      send_item(24'sh123456, 1);
      // random runs across three idle profiles
      for (int ph = 0; ph < 3; ph++) begin
         idle_pct = (ph == 0) ? 37 : (ph == 1) ? 56 : 0;
         for (int j = 0; j < 17; ) begin
            int n;
            n = $urandom_range(1, 6);
            send_run(n, 1);
            j += n;
         end
      end
      start <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (board.errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ----- files.f -----
sv/smx_pkg.sv
sv/smx_ctrl.sv
sv/smx_dpath.sv
sv/softmax_exp2_polynomial.sv
bench/tb_softmax_exp2_polynomial.sv
